// ===== rtl/core/vrp_pkg.sv =====
package vrp_pkg;

  localparam int unsigned CFG_DATA_W = 2;
  localparam int unsigned CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIRRORING = 1'd0,
    CFG_CHR_WRITABLE = 1'd1
  } cfg_index_t;

  typedef enum logic {
    OP_READ = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  localparam logic [2:0] REG_CTRL = 3'd0;
  localparam logic [2:0] REG_MASK = 3'd1;
  localparam logic [2:0] REG_STATUS = 3'd2;
  localparam logic [2:0] REG_OAM_ADDR = 3'd3;
  localparam logic [2:0] REG_OAM_DATA = 3'd4;
  localparam logic [2:0] REG_SCROLL = 3'd5;
  localparam logic [2:0] REG_ADDR = 3'd6;
  localparam logic [2:0] REG_DATA = 3'd7;

  localparam logic [1:0] MIR_VERTICAL = 2'd0;
  localparam logic [1:0] MIR_HORIZONTAL = 2'd1;
  localparam logic [1:0] MIR_SINGLE_LO = 2'd2;
  localparam logic [1:0] MIR_SINGLE_HI = 2'd3;

  typedef struct packed {
    logic       op;
    logic [2:0] reg_index;
    logic [7:0] write_data;
    logic [2:0] status_bits;
  } access_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [15:0] vram_addr;
    logic [14:0] temp_addr;
    logic [7:0]  ctrl_byte;
    logic [7:0]  mask_byte;
    logic [7:0]  scroll_x_out;
    logic [7:0]  scroll_y_out;
    logic        nmi_ack;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic load;    // capture access, issue memory reads
    logic finish;  // apply update, write memories, build result
  } vrp_cmd_t;

  // Palette index with background aliasing.
  function automatic logic [4:0] pal_slot(input logic [13:0] a);
    logic [4:0] s;
    begin
      s = a[4:0];
      if (a[1:0] == 2'b00 && a[4]) s = {1'b0, a[3:0]};
      return s;
    end
  endfunction

endpackage

// ===== rtl/core/vrp_access_if.sv =====
interface vrp_access_if;
  import vrp_pkg::*;
  logic    valid;
  logic    ready;
  access_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/vrp_result_if.sv =====
interface vrp_result_if;
  import vrp_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/vrp_ram.sv =====
module vrp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/vrp_ctrl.sv =====
module vrp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  logic              clear_done,
  output vrp_pkg::vrp_cmd_t cmd
);
  import vrp_pkg::*;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;

  // a result may wait in the output register while the next access is taken;
  // that access does not finish until the result drains
  assign in_ready = (state == S_IDLE);
  assign cmd.load = (state == S_IDLE) && in_valid;
  assign cmd.finish = (state == S_EXEC) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.finish || (out_valid && !out_ready);
      case (state)
        S_CLEAR: if (clear_done) state <= S_IDLE;
        S_IDLE: if (in_valid) state <= S_EXEC;
        S_EXEC: if (cmd.finish) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/core/vrp_datapath.sv =====
module vrp_datapath #(
  parameter int unsigned NAMETABLE_BYTES = 2048,
  parameter int unsigned PATTERN_BYTES = 8192
) (
  input  logic              clk,
  input  logic              rst,
  input  vrp_pkg::vrp_cmd_t cmd,
  input  vrp_pkg::access_t  acc_in,
  input  logic [1:0]        mirroring_mode,
  input  logic              chr_writable,
  output logic              clear_done,
  output vrp_pkg::result_t  res
);
  import vrp_pkg::*;

  localparam int unsigned NT_AW = $clog2(NAMETABLE_BYTES);
  localparam int unsigned PT_AW = $clog2(PATTERN_BYTES);
  localparam int unsigned CLR_W = PT_AW + 1;

  logic [15:0] cur_addr;
  logic [14:0] tmp_addr;
  logic        second_write;
  logic [7:0]  read_buffer, open_bus, sprite_index;
  logic [7:0]  ctrl_reg, mask_reg, scroll_x, scroll_y;
  logic [7:0]  rd_q;
  logic        ack_q;
  access_t     acc;

  // clearing sweep over every store
  logic [CLR_W-1:0] clr_cnt;
  logic             clearing;
  assign clearing = !clr_cnt[PT_AW];
  assign clear_done = !clearing;

  always_ff @(posedge clk) begin
    if (rst) clr_cnt <= '0;
    else if (clearing) clr_cnt <= clr_cnt + 1'b1;
  end

  logic [13:0] va;
  assign va = cur_addr[13:0];

  // nametable slot by mirroring mode
  logic [10:0] nt_slot;
  always_comb begin
    case (mirroring_mode)
      MIR_VERTICAL: nt_slot = va[10:0];
      MIR_HORIZONTAL: nt_slot = {va[11], va[9:0]};
      MIR_SINGLE_LO: nt_slot = {1'b0, va[9:0]};
      MIR_SINGLE_HI: nt_slot = {1'b1, va[9:0]};
      default: nt_slot = va[10:0];
    endcase
  end

  logic is_pat, is_nt, is_pal;
  assign is_pat = (va <= 14'h1FFF);
  assign is_pal = (va > 14'h3EFF);
  assign is_nt = !is_pat && !is_pal;

  // read addresses follow the current address, which holds until finish;
  // palette reads refill the buffer from the unmirrored table
  logic [NT_AW-1:0] nt_raddr;
  always_comb begin
    if (is_pal)
      nt_raddr = NT_AW'(va[10:0]);
    else
      nt_raddr = NT_AW'(nt_slot);
  end

  logic [7:0] nt_rd, pal_rd, spr_rd, pat_rd;
  logic       is_wr, is_data, is_spr;
  assign is_wr = (acc.op == OP_WRITE);
  assign is_data = (acc.reg_index == REG_DATA);
  assign is_spr = (acc.reg_index == REG_OAM_DATA);

  logic nt_we, pal_we, spr_we, pat_we;
  assign nt_we = clearing || (cmd.finish && is_wr && is_data && is_nt);
  assign pal_we = clearing || (cmd.finish && is_wr && is_data && is_pal);
  assign spr_we = clearing || (cmd.finish && is_wr && is_spr);
  assign pat_we = clearing || (cmd.finish && is_wr && is_data && is_pat && chr_writable);

  logic [7:0] wdat;
  assign wdat = clearing ? 8'h00 : acc.write_data;

  vrp_ram #(.WIDTH(8), .DEPTH(NAMETABLE_BYTES)) u_nt (
    .clk, .we(nt_we),
    .waddr(clearing ? clr_cnt[NT_AW-1:0] : NT_AW'(nt_slot)),
    .wdata(wdat), .raddr(nt_raddr), .rdata(nt_rd));

  vrp_ram #(.WIDTH(8), .DEPTH(32)) u_pal (
    .clk, .we(pal_we),
    .waddr(clearing ? clr_cnt[4:0] : pal_slot(va)),
    .wdata(wdat), .raddr(pal_slot(va)), .rdata(pal_rd));

  vrp_ram #(.WIDTH(8), .DEPTH(256)) u_spr (
    .clk, .we(spr_we),
    .waddr(clearing ? clr_cnt[7:0] : sprite_index),
    .wdata(wdat), .raddr(sprite_index), .rdata(spr_rd));

  vrp_ram #(.WIDTH(8), .DEPTH(PATTERN_BYTES)) u_pat (
    .clk, .we(pat_we),
    .waddr(clearing ? clr_cnt[PT_AW-1:0] : PT_AW'(va[12:0])),
    .wdata(wdat), .raddr(PT_AW'(va[12:0])), .rdata(pat_rd));

  logic [7:0] vid_rd;
  always_comb begin
    if (is_pat) vid_rd = pat_rd;
    else if (is_nt) vid_rd = nt_rd;
    else vid_rd = pal_rd;
  end

  logic [15:0] cur_inc;
  assign cur_inc = cur_addr + (ctrl_reg[2] ? 16'd32 : 16'd1);

  always_ff @(posedge clk) begin
    if (cmd.load) acc <= acc_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_addr <= '0; tmp_addr <= '0; second_write <= 1'b0;
      read_buffer <= '0; open_bus <= '0; sprite_index <= '0;
      ctrl_reg <= '0; mask_reg <= '0; scroll_x <= '0; scroll_y <= '0;
      rd_q <= '0; ack_q <= 1'b0;
    end else if (cmd.finish) begin
      ack_q <= 1'b0;
      rd_q <= 8'h00;
      if (is_wr) begin
        open_bus <= acc.write_data;
        case (acc.reg_index)
          REG_CTRL: begin
            ctrl_reg <= acc.write_data;
            tmp_addr[11:10] <= acc.write_data[1:0];
            ack_q <= !acc.write_data[7];
          end
          REG_MASK: mask_reg <= acc.write_data;
          REG_OAM_ADDR: sprite_index <= acc.write_data;
          REG_OAM_DATA: sprite_index <= sprite_index + 8'd1;
          REG_SCROLL: begin
            if (second_write) begin
              scroll_y <= acc.write_data;
              tmp_addr[9:5] <= acc.write_data[7:3];
              tmp_addr[14:12] <= acc.write_data[2:0];
            end else begin
              scroll_x <= acc.write_data;
              tmp_addr[4:0] <= acc.write_data[7:3];
            end
            second_write <= !second_write;
          end
          REG_ADDR: begin
            if (second_write) begin
              tmp_addr[7:0] <= acc.write_data;
              cur_addr <= {1'b0, tmp_addr[14:8], acc.write_data};
            end else begin
              tmp_addr[14:8] <= {1'b0, acc.write_data[5:0]};
            end
            second_write <= !second_write;
          end
          REG_DATA: cur_addr <= cur_inc;
          default: ;
        endcase
      end else begin
        case (acc.reg_index)
          REG_STATUS: begin
            second_write <= 1'b0;
            rd_q <= {acc.status_bits, open_bus[4:0]};
            open_bus <= {acc.status_bits, open_bus[4:0]};
          end
          REG_OAM_DATA: begin
            rd_q <= spr_rd;
            open_bus <= spr_rd;
          end
          REG_DATA: begin
            if (!is_pal) begin
              rd_q <= read_buffer;
              open_bus <= read_buffer;
              read_buffer <= vid_rd;
            end else begin
              rd_q <= pal_rd;
              open_bus <= pal_rd;
              read_buffer <= nt_rd;
            end
            cur_addr <= cur_inc;
          end
          default: rd_q <= open_bus;
        endcase
      end
    end
  end

  // fields that track the registers just updated
  always_comb begin
    res.read_data = rd_q;
    res.vram_addr = cur_addr;
    res.temp_addr = tmp_addr;
    res.ctrl_byte = ctrl_reg;
    res.mask_byte = mask_reg;
    res.scroll_x_out = scroll_x;
    res.scroll_y_out = scroll_y;
    res.nmi_ack = ack_q;
  end
endmodule

// ===== rtl/core/video_register_port_with_vram.sv =====
// Channel  Dir  Payload
// acc      in   op, reg_index, write_data, status_bits
// res      out  read_data, vram_addr, temp_addr, ctrl/mask/scroll bytes, nmi_ack
// cfg      in   cfg_we, cfg_index, cfg_data (mirroring_mode, chr_writable)
//
// Each access is handled in steps: a capture step that addresses the memories,
// then a write-back step that takes the registered read data. A new access is
// taken only once the previous one has finished. After reset a sweep zeroes all
// stores before the first access is taken. A stalled result holds the next access
// in its write-back step; a new access is taken while the previous result waits.
module video_register_port_with_vram #(
  parameter int unsigned NAMETABLE_BYTES = 2048,
  parameter int unsigned PATTERN_BYTES = 8192
) (
  input logic                              clk,
  input logic                              rst,
  vrp_access_if.sink                       acc,
  vrp_result_if.source                     res,
  input logic                              cfg_we,
  input logic [vrp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input logic [vrp_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import vrp_pkg::*;

  logic [1:0] mirroring_mode;
  logic       chr_writable;
  logic       clear_done;
  vrp_cmd_t   cmd;
  result_t    r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mirroring_mode <= MIR_VERTICAL;
      chr_writable <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIRRORING: mirroring_mode <= cfg_data[1:0];
        CFG_CHR_WRITABLE: chr_writable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  vrp_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(acc.valid), .in_ready(acc.ready),
    .out_valid(res.valid), .out_ready(res.ready),
    .clear_done, .cmd);

  vrp_datapath #(.NAMETABLE_BYTES(NAMETABLE_BYTES), .PATTERN_BYTES(PATTERN_BYTES)) u_dp (
    .clk, .rst, .cmd, .acc_in(acc.data),
    .mirroring_mode, .chr_writable, .clear_done, .res(r));

  assign res.data = r;
endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import vrp_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  vrp_access_if acc ();
  vrp_result_if res ();

  video_register_port_with_vram u_top (
    .clk(clk),
    .rst(rst),
    .acc(acc.sink),
    .res(res.source),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the register port: addresses, latch, buffers and stores.
  logic [1:0]  mirror;
  logic        chr_wr;
  logic [15:0] v_addr;
  logic [14:0] t_addr;
  logic        latch;
  logic [7:0]  rbuf, bus_byte, spr_idx, ctrl_q, mask_q, sx_q, sy_q;
  logic [7:0]  nt_mem [0:2047];
  logic [7:0]  pal_mem [0:31];
  logic [7:0]  spr_mem [0:255];
  logic [7:0]  chr_mem [0:8191];

  result_t pending_results[$];
  int      errors = 0;

  // Idling per phase: none, sender idle (72 %), receiver stall (72 %), both (30 %)
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  bit long_hold = 1'b0;

  function automatic logic [10:0] nt_index(input logic [13:0] a);
    case (mirror)
      MIR_VERTICAL:   return a[10:0];
      MIR_HORIZONTAL: return {a[11], a[9:0]};
      MIR_SINGLE_LO:  return {1'b0, a[9:0]};
      default:        return {1'b1, a[9:0]};
    endcase
  endfunction

  function automatic logic [4:0] color_index(input logic [13:0] a);
    // the sprite palette zero slots alias onto the background entries
    return (a[1:0] == 2'b00) ? {1'b0, a[3:0]} : a[4:0];
  endfunction

  function automatic logic [7:0] vmem_read(input logic [13:0] a);
    if (a < 14'h2000) return chr_mem[a[12:0]];
    if (a <= 14'h3EFF) return nt_mem[nt_index(a)];
    return pal_mem[color_index(a)];
  endfunction

  function automatic void vmem_write(input logic [13:0] a, input logic [7:0] v);
    if (a < 14'h2000) begin
      if (chr_wr) chr_mem[a[12:0]] = v;
    end else if (a <= 14'h3EFF) begin
      nt_mem[nt_index(a)] = v;
    end else begin
      pal_mem[color_index(a)] = v;
    end
  endfunction

  function automatic result_t port_access(input access_t a);
    result_t     r;
    logic [7:0]  v, val;
    logic [13:0] va;
    logic [14:0] t;
    logic        ack;
    v = a.write_data;
    t = t_addr;
    ack = 1'b0;
    r.read_data = 8'h00;
    if (a.op == OP_WRITE) begin
      bus_byte = v;
      case (a.reg_index)
        REG_CTRL: begin
          ctrl_q = v;
          t = (t & 15'h73FF) | (15'(v[1:0]) << 10);
          ack = ~v[7];
        end
        REG_MASK: mask_q = v;
        REG_OAM_ADDR: spr_idx = v;
        REG_OAM_DATA: begin
          spr_mem[spr_idx] = v;
          spr_idx = spr_idx + 8'd1;
        end
        REG_SCROLL: begin
          if (latch) begin
            sy_q = v;
            t = (t & 15'h7C1F) | (15'(v[7:3]) << 5);
            t = (t & 15'h0FFF) | (15'(v[2:0]) << 12);
          end else begin
            sx_q = v;
            t = (t & 15'h7FE0) | 15'(v[7:3]);
          end
          latch = ~latch;
        end
        REG_ADDR: begin
          if (latch) begin
            t = (t & 15'h7F00) | 15'(v);
            v_addr = {1'b0, t};
          end else begin
            t = (t & 15'h00FF) | (15'(v[5:0]) << 8);
          end
          latch = ~latch;
        end
        REG_DATA: begin
          vmem_write(v_addr[13:0], v);
          v_addr = v_addr + (ctrl_q[2] ? 16'd32 : 16'd1);
        end
        default: ;
      endcase
      t_addr = t;
    end else begin
      case (a.reg_index)
        REG_STATUS: begin
          latch = 1'b0;
          r.read_data = {a.status_bits, bus_byte[4:0]};
          bus_byte = r.read_data;
        end
        REG_OAM_DATA: begin
          r.read_data = spr_mem[spr_idx];
          bus_byte = r.read_data;
        end
        REG_DATA: begin
          va = v_addr[13:0];
          val = vmem_read(va);
          if (va <= 14'h3EFF) begin
            r.read_data = rbuf;
            rbuf = val;
          end else begin
            // palette reads bypass the buffer, which refills from the unmirrored table
            rbuf = nt_mem[va[10:0]];
            r.read_data = val;
          end
          v_addr = v_addr + (ctrl_q[2] ? 16'd32 : 16'd1);
          bus_byte = r.read_data;
        end
        default: r.read_data = bus_byte;
      endcase
    end
    r.vram_addr = v_addr;
    r.temp_addr = t_addr;
    r.ctrl_byte = ctrl_q;
    r.mask_byte = mask_q;
    r.scroll_x_out = sx_q;
    r.scroll_y_out = sy_q;
    r.nmi_ack = ack;
    return r;
  endfunction

  function automatic access_t mk(input logic o, input logic [2:0] r, input logic [7:0] d);
    access_t a;
    a.op = o;
    a.reg_index = r;
    a.write_data = d;
    a.status_bits = 3'($urandom_range(7));
    return a;
  endfunction

  // Offer one beat; called at a falling edge, returns at the falling edge after acceptance.
  task automatic send_beat(input access_t a, input bit has_rd, input logic [7:0] rd);
    result_t r;
    while ($urandom_range(99) < tx_idle_pct) begin
      acc.valid <= 1'b0;
      @(negedge clk);
    end
    acc.valid <= 1'b1;
    acc.data <= a;
    do @(posedge clk); while (!acc.ready);
    r = port_access(a);
    if (has_rd) r.read_data = rd;
    pending_results.push_back(r);
    @(negedge clk);
  endtask

  task automatic drain;
    acc.valid <= 1'b0;
    wait (pending_results.size() == 0);
    // let the last access finish its write-back
    repeat (4) @(negedge clk);
  endtask

  task automatic set_cfg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MIRRORING) mirror = val;
    else chr_wr = val[0];
  endtask

  // Receiver: random stall, or a long hold-off while long_hold is set.
  always @(negedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else if (long_hold) begin
      res.ready <= 1'b0;
    end else begin
      res.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  initial begin
    forever begin
      wait (long_hold == 1'b1);
      repeat (300) @(negedge clk);
      long_hold = 1'b0;
    end
  end

  task automatic cmp(input string name, input logic [15:0] e, input logic [15:0] g);
    if (e !== g) begin
      errors++;
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, e, g);
    end
  endtask

  // Check each result beat against the oldest expectation.
  always @(posedge clk) begin
    result_t e;
    if (!rst && res.valid && res.ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, got %h", $time, res.data);
      end else begin
        e = pending_results.pop_front();
        cmp("read_data", e.read_data, res.data.read_data);
        cmp("vram_addr", e.vram_addr, res.data.vram_addr);
        cmp("temp_addr", e.temp_addr, res.data.temp_addr);
        cmp("ctrl_byte", e.ctrl_byte, res.data.ctrl_byte);
        cmp("mask_byte", e.mask_byte, res.data.mask_byte);
        cmp("scroll_x_out", e.scroll_x_out, res.data.scroll_x_out);
        cmp("scroll_y_out", e.scroll_y_out, res.data.scroll_y_out);
        cmp("nmi_ack", e.nmi_ack, res.data.nmi_ack);
      end
    end
  end

  initial begin
    #40_000_000;
    $display("tb NOT OK");
    $finish;
  end

  typedef struct {
    access_t     a;
    bit          has_rd;
    logic [7:0]  rd;
  } dir_row_t;

  dir_row_t dir_rows[$];

  function automatic void row(input logic o, input logic [2:0] r, input logic [7:0] d,
                              input logic [2:0] st, input bit has_rd, input logic [7:0] rd);
    dir_row_t x;
    x.a.op = o;
    x.a.reg_index = r;
    x.a.write_data = d;
    x.a.status_bits = st;
    x.has_rd = has_rd;
    x.rd = rd;
    dir_rows.push_back(x);
  endfunction

  // Random part: mostly address-then-data sequences, some noise.
  task automatic random_phase(input int n_items);
    int cnt, k;
    logic [7:0] hi;
    cnt = 0;
    while (cnt < n_items) begin
      if ($urandom_range(99) < 70) begin
        if ($urandom_range(3) == 0) begin
          send_beat(mk(OP_READ, REG_STATUS, 8'($urandom)), 0, 0);
          cnt++;
        end
        if ($urandom_range(4) == 0) begin
          send_beat(mk(OP_WRITE, REG_CTRL, 8'($urandom)), 0, 0);
          cnt++;
        end
        case ($urandom_range(3))
          0: hi = 8'($urandom_range(8'h1F));
          1: hi = 8'($urandom_range(8'h3E, 8'h20));
          2: hi = 8'h3F;
          default: hi = 8'($urandom);
        endcase
        send_beat(mk(OP_WRITE, REG_ADDR, hi), 0, 0);
        send_beat(mk(OP_WRITE, REG_ADDR, 8'($urandom)), 0, 0);
        cnt += 2;
        repeat ($urandom_range(8, 1)) begin
          k = $urandom_range(9);
          if (k < 4) send_beat(mk(OP_WRITE, REG_DATA, 8'($urandom)), 0, 0);
          else if (k < 8) send_beat(mk(OP_READ, REG_DATA, 8'($urandom)), 0, 0);
          else if (k == 8) send_beat(mk(OP_WRITE, REG_OAM_DATA, 8'($urandom)), 0, 0);
          else send_beat(mk(OP_READ, REG_OAM_DATA, 8'($urandom)), 0, 0);
          cnt++;
        end
      end else begin
        send_beat(mk(1'($urandom), 3'($urandom), 8'($urandom)), 0, 0);
        cnt++;
      end
    end
  endtask

  initial begin
    acc.valid = 1'b0;
    acc.data = '0;
    res.ready = 1'b0;
    mirror = MIR_VERTICAL;
    chr_wr = 1'b0;
    v_addr = '0;
    t_addr = '0;
    latch = 1'b0;
    rbuf = '0;
    bus_byte = '0;
    spr_idx = '0;
    ctrl_q = '0;
    mask_q = '0;
    sx_q = '0;
    sy_q = '0;
    for (int i = 0; i < 2048; i++) nt_mem[i] = '0;
    for (int i = 0; i < 32; i++) pal_mem[i] = '0;
    for (int i = 0; i < 256; i++) spr_mem[i] = '0;
    for (int i = 0; i < 8192; i++) chr_mem[i] = '0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed rows: read values typed in where obvious, predictor elsewhere.
    row(OP_READ,  REG_STATUS,   8'h00, 3'd7, 1, 8'hE0); // status after reset
    row(OP_READ,  REG_CTRL,     8'h00, 3'd0, 1, 8'hE0); // write-only read gives open bus
    row(OP_WRITE, REG_CTRL,     8'h00, 3'd0, 0, 0);     // NMI off acknowledge
    row(OP_WRITE, REG_CTRL,     8'hFF, 3'd0, 0, 0);     // increment by 32
    row(OP_WRITE, REG_MASK,     8'hFF, 3'd0, 0, 0);
    row(OP_WRITE, REG_OAM_ADDR, 8'hFF, 3'd0, 0, 0);
    row(OP_WRITE, REG_OAM_DATA, 8'hAB, 3'd0, 0, 0);     // index wraps to zero
    row(OP_READ,  REG_OAM_DATA, 8'h00, 3'd0, 1, 8'h00);
    row(OP_WRITE, REG_SCROLL,   8'hFF, 3'd0, 0, 0);
    row(OP_WRITE, REG_SCROLL,   8'hFF, 3'd0, 0, 0);
    row(OP_WRITE, REG_ADDR,     8'h3F, 3'd0, 0, 0);
    row(OP_WRITE, REG_ADDR,     8'h10, 3'd0, 0, 0);
    row(OP_WRITE, REG_DATA,     8'h5A, 3'd0, 0, 0);     // aliased palette entry
    row(OP_WRITE, REG_ADDR,     8'h3F, 3'd0, 0, 0);
    row(OP_WRITE, REG_ADDR,     8'h00, 3'd0, 0, 0);
    row(OP_READ,  REG_DATA,     8'h00, 3'd0, 1, 8'h5A); // palette read is direct
    row(OP_WRITE, REG_CTRL,     8'h80, 3'd0, 0, 0);
    row(OP_WRITE, REG_ADDR,     8'hFF, 3'd0, 0, 0);     // top bits of the address dropped
    row(OP_WRITE, REG_ADDR,     8'hFF, 3'd0, 0, 0);
    row(OP_READ,  REG_DATA,     8'h00, 3'd5, 0, 0);
    row(OP_WRITE, REG_ADDR,     8'h00, 3'd0, 0, 0);
    row(OP_WRITE, REG_ADDR,     8'h00, 3'd0, 0, 0);
    row(OP_WRITE, REG_DATA,     8'h77, 3'd0, 0, 0);     // pattern store read-only
    row(OP_READ,  REG_DATA,     8'h00, 3'd0, 0, 0);
    row(OP_READ,  REG_DATA,     8'h00, 3'd0, 0, 0);
    row(OP_WRITE, REG_STATUS,   8'h1F, 3'd0, 0, 0);
    row(OP_READ,  REG_SCROLL,   8'h00, 3'd2, 1, 8'h1F);
    row(OP_READ,  REG_ADDR,     8'h00, 3'd0, 1, 8'h1F);
    foreach (dir_rows[i]) send_beat(dir_rows[i].a, dir_rows[i].has_rd, dir_rows[i].rd);
    drain();

    // Eight phases over all settings and idling modes.
    for (int ph = 0; ph < 8; ph++) begin
      set_cfg(CFG_MIRRORING, 2'(ph % 4));
      set_cfg(CFG_CHR_WRITABLE, 2'(ph / 2 % 2 == 0 ? ph % 2 : 1 - ph % 2));
      case (ph % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 72; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 72; end
        default: begin tx_idle_pct = 30; rx_stall_pct = 30; end
      endcase
      if (ph == 4) long_hold = 1'b1;  // block fills and stalls its input
      random_phase(80);
      if (ph == 5) begin
        // hold the sender until every outstanding result is back
        acc.valid <= 1'b0;
        wait (pending_results.size() == 0);
        @(negedge clk);
      end
      random_phase(80);
      drain();
    end

    repeat (20) @(negedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
